### hw/rtl/rabc_pkg.sv
package rabc_pkg;

   // Command carried in the tuser field of each input item.
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_PRESS = 2'd1,
      CMD_START = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Register indexes on the configuration port (word address).
   localparam logic [2:0] REG_START_HOUR     = 3'd0;
   localparam logic [2:0] REG_ALARM_INTERVAL = 3'd1;
   localparam logic [2:0] REG_LATEST_HOUR    = 3'd2;
   localparam logic [2:0] REG_SNOOZE_HOURS   = 3'd3;
   localparam logic [2:0] REG_BUZZ_LIMIT     = 3'd4;

   // Register reset values.
   localparam logic [5:0] START_HOUR_RST     = 6'h11;
   localparam logic [5:0] ALARM_INTERVAL_RST = 6'h04;
   localparam logic [5:0] LATEST_HOUR_RST    = 6'h19;
   localparam logic [5:0] SNOOZE_HOURS_RST   = 6'h01;
   localparam logic [9:0] BUZZ_LIMIT_RST     = 10'd600;

   // The pin is pulsed high when the beep phase reaches this value.
   localparam logic [2:0] BEEP_EVERY = 3'd4;

   // Packed-BCD hour plus offset, digit by digit with decimal adjust. The
   // offset is first normalised on its own; the result may exceed six bits.
   function automatic logic [7:0] bcd_hour_add(input logic [5:0] hour,
                                                input logic [5:0] offset);
      logic       c_norm;
      logic [3:0] lo_norm;
      logic [2:0] hi_norm;
      logic [4:0] sum_lo;
      logic       c_lo;
      logic [4:0] adj_lo;
      logic [3:0] sum_hi;
      c_norm  = (offset[3:0] > 4'd9);
      lo_norm = c_norm ? (offset[3:0] - 4'd10) : offset[3:0];
      hi_norm = {1'b0, offset[5:4]} + {2'b00, c_norm};
      sum_lo  = {1'b0, hour[3:0]} + {1'b0, lo_norm};
      c_lo    = (sum_lo > 5'd9);
      adj_lo  = c_lo ? (sum_lo - 5'd10) : sum_lo;
      sum_hi  = {2'b00, hour[5:4]} + {1'b0, hi_norm} + {3'b000, c_lo};
      return {sum_hi, adj_lo[3:0]};
   endfunction

endpackage

### hw/rtl/reminder_alarm_buzzer_controller_core.sv
// Result items are registered: an accepted item waits in the input register until the
// result register is free or being emptied. One item per cycle while the result channel does
// not stall; the whole update of the alarm state is one combinational pass between the two.
// Reset (synchronous, active high) empties both registers, loads the default
// configuration and clears the buzzer state, with the alarm hour at the start hour.
module reminder_alarm_buzzer_controller_core (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] current_hour, [7:6] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] buzz_pin, [1] alarm_active,
                                    // [7:2] next_alarm_hour, [17:8] seconds_left,
                                    // [23:18] zero
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers
   logic [5:0] start_hour_ff;
   logic [5:0] alarm_interval_ff;
   logic [5:0] latest_hour_ff;
   logic [5:0] snooze_hours_ff;
   logic [9:0] buzz_limit_ff;

   // Alarm state
   logic [9:0] buzz_countdown_ff, buzz_countdown_in;
   logic       buzz_active_ff, buzz_active_in;
   logic [2:0] beep_phase_ff, beep_phase_in;
   logic       early_press_ff, early_press_in;
   logic [5:0] alarm_hour_ff, alarm_hour_in;
   logic       pin_level_ff, pin_level_in;

   // Input and result registers
   logic       in_valid_ff;
   logic [1:0] in_cmd_ff;
   logic [5:0] in_hour_ff;
   logic       out_valid_ff;
   logic       out_pin_ff;
   logic       out_active_ff;
   logic [5:0] out_hour_ff;
   logic [9:0] out_seconds_ff;

   logic       advance;
   logic [2:0] csr_index;
   logic       csr_write;

   // Scheduling terms
   logic [5:0] sched_offset;
   logic [7:0] sched_sum;
   logic       sched_early;
   logic       sched_fallback;
   logic [5:0] sched_hour;
   logic       sched_early_out;

   // An item moves on when the result register is free or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_seconds_ff, out_hour_ff, out_active_ff, out_pin_ff};

   // Configuration port: always ready, write in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_hour_ff     <= rabc_pkg::START_HOUR_RST;
         alarm_interval_ff <= rabc_pkg::ALARM_INTERVAL_RST;
         latest_hour_ff    <= rabc_pkg::LATEST_HOUR_RST;
         snooze_hours_ff   <= rabc_pkg::SNOOZE_HOURS_RST;
         buzz_limit_ff     <= rabc_pkg::BUZZ_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            rabc_pkg::REG_START_HOUR:     start_hour_ff     <= csr_pwdata[5:0];
            rabc_pkg::REG_ALARM_INTERVAL: alarm_interval_ff <= csr_pwdata[5:0];
            rabc_pkg::REG_LATEST_HOUR:    latest_hour_ff    <= csr_pwdata[5:0];
            rabc_pkg::REG_SNOOZE_HOURS:   snooze_hours_ff   <= csr_pwdata[5:0];
            rabc_pkg::REG_BUZZ_LIMIT:     buzz_limit_ff     <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         rabc_pkg::REG_START_HOUR:     csr_prdata = {26'd0, start_hour_ff};
         rabc_pkg::REG_ALARM_INTERVAL: csr_prdata = {26'd0, alarm_interval_ff};
         rabc_pkg::REG_LATEST_HOUR:    csr_prdata = {26'd0, latest_hour_ff};
         rabc_pkg::REG_SNOOZE_HOURS:   csr_prdata = {26'd0, snooze_hours_ff};
         rabc_pkg::REG_BUZZ_LIMIT:     csr_prdata = {22'd0, buzz_limit_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // Next alarm hour: BCD sum, falling back to the start hour when the sum is
   // too late, or too early without a recorded early press.
   always_comb begin
      sched_offset    = (in_cmd_ff == rabc_pkg::CMD_TICK) ? snooze_hours_ff
                                                           : alarm_interval_ff;
      sched_sum       = rabc_pkg::bcd_hour_add(in_hour_ff, sched_offset);
      sched_early     = early_press_ff ||
                        ((in_cmd_ff == rabc_pkg::CMD_PRESS) && !buzz_active_ff);
      sched_fallback  = (sched_sum > {2'b00, latest_hour_ff}) ||
                        ((sched_sum < {2'b00, start_hour_ff}) && !sched_early);
      sched_hour      = sched_fallback ? start_hour_ff : sched_sum[5:0];
      sched_early_out = sched_fallback ? 1'b0 : sched_early;
   end

   // State update for the item in the input register.
   always_comb begin
      buzz_countdown_in = buzz_countdown_ff;
      buzz_active_in    = buzz_active_ff;
      beep_phase_in     = beep_phase_ff;
      early_press_in    = early_press_ff;
      alarm_hour_in     = alarm_hour_ff;
      pin_level_in      = pin_level_ff;
      case (in_cmd_ff)
         rabc_pkg::CMD_TICK: begin
            if (buzz_active_ff && (buzz_countdown_ff != 10'd0)) begin
               // Running buzzer: count down and pulse every fifth second.
               buzz_countdown_in = buzz_countdown_ff - 10'd1;
               if (beep_phase_ff == rabc_pkg::BEEP_EVERY) begin
                  pin_level_in  = 1'b1;
                  beep_phase_in = 3'd0;
               end else begin
                  pin_level_in  = 1'b0;
                  beep_phase_in = beep_phase_ff + 3'd1;
               end
            end else if (buzz_active_ff) begin
               // Unanswered buzz timed out: stop and snooze.
               buzz_active_in    = 1'b0;
               buzz_countdown_in = 10'd0;
               pin_level_in      = 1'b0;
               alarm_hour_in     = sched_hour;
               early_press_in    = sched_early_out;
            end else if (in_hour_ff == alarm_hour_ff) begin
               pin_level_in      = 1'b1;
               buzz_active_in    = 1'b1;
               buzz_countdown_in = buzz_limit_ff;
            end
         end
         rabc_pkg::CMD_PRESS: begin
            if (buzz_active_ff || (!early_press_ff && (in_hour_ff < start_hour_ff))) begin
               buzz_active_in    = 1'b0;
               buzz_countdown_in = 10'd0;
               pin_level_in      = 1'b0;
               alarm_hour_in     = sched_hour;
               early_press_in    = sched_early_out;
            end
         end
         rabc_pkg::CMD_START: begin
            if (in_hour_ff >= start_hour_ff) begin
               alarm_hour_in  = sched_hour;
               early_press_in = sched_early_out;
            end else begin
               alarm_hour_in  = start_hour_ff;
            end
            buzz_active_in    = 1'b0;
            buzz_countdown_in = 10'd0;
            pin_level_in      = 1'b0;
         end
         default: ;
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         buzz_countdown_ff <= 10'd0;
         buzz_active_ff    <= 1'b0;
         beep_phase_ff     <= 3'd0;
         early_press_ff    <= 1'b0;
         alarm_hour_ff     <= rabc_pkg::START_HOUR_RST;
         pin_level_ff      <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff      <= 1'b1;
            buzz_countdown_ff <= buzz_countdown_in;
            buzz_active_ff    <= buzz_active_in;
            beep_phase_ff     <= beep_phase_in;
            early_press_ff    <= early_press_in;
            alarm_hour_ff     <= alarm_hour_in;
            pin_level_ff      <= pin_level_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tuser;
         in_hour_ff <= req_tdata[5:0];
      end
      if (advance) begin
         out_pin_ff     <= pin_level_in;
         out_active_ff  <= buzz_active_in;
         out_hour_ff    <= alarm_hour_in;
         out_seconds_ff <= buzz_active_in ? buzz_countdown_in : 10'd0;
      end
   end

   // An idle buzzer holds no count and drives no pin.
   assert property (@(posedge clock) disable iff (reset)
      !buzz_active_ff |-> (buzz_countdown_ff == 10'd0) && !pin_level_ff)
      else $error("idle buzzer holds a count or drives the pin");

   // A result reports remaining seconds only while the alarm is active.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_active_ff |-> (out_seconds_ff == 10'd0))
      else $error("seconds reported while alarm inactive");

   // A start before the start hour sets the alarm to the start hour.
   assert property (@(posedge clock) disable iff (reset)
      advance && (in_cmd_ff == rabc_pkg::CMD_START) && (in_hour_ff < start_hour_ff)
      |=> (alarm_hour_ff == $past(start_hour_ff)) && !buzz_active_ff)
      else $error("start event did not load the start hour");

endmodule

### sim/tb_reminder_alarm_buzzer_controller_core.sv
`timescale 1ns / 100ps

module tb_reminder_alarm_buzzer_controller_core;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_WAIT       = 18;
   localparam int SETTLE_CYCLES  = 8;

   // One result item as the block reports it, highest field first.
   typedef struct packed {
      logic [9:0] secs;
      logic [5:0] hour;
      logic       active;
      logic       pin;
   } alarm_status_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [5:0] current_hour, [7:6] zero
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [0] buzz_pin, [1] alarm_active, [7:2] next_alarm_hour,
                             // [17:8] seconds_left, [23:18] zero
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow configuration.
   logic [5:0] first_hour  = rabc_pkg::START_HOUR_RST;
   logic [5:0] step_hours  = rabc_pkg::ALARM_INTERVAL_RST;
   logic [5:0] last_hour   = rabc_pkg::LATEST_HOUR_RST;
   logic [5:0] snooze_step = rabc_pkg::SNOOZE_HOURS_RST;
   logic [9:0] buzz_limit  = rabc_pkg::BUZZ_LIMIT_RST;

   // Shadow alarm state.
   logic [9:0] countdown  = '0;
   logic       sounding   = 1'b0;
   logic [2:0] phase_ctr  = '0;
   logic       early_mark = 1'b0;
   logic [5:0] sched_hour = rabc_pkg::START_HOUR_RST;
   logic       pin        = 1'b0;

   alarm_status_type pending_status[$];
   alarm_status_type want_status;
   alarm_status_type got_status;

   int  err_count    = 0;
   int  items_sent   = 0;
   int  results_seen = 0;
   int  csr_writes   = 0;
   int  settings     = 0;
   int  stall_left   = 0;
   int  idle_cycles  = 0;
   bit  gaps_on      = 1'b1;
   bit  stalls_on    = 1'b1;

   reminder_alarm_buzzer_controller_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock with an 8 ns period.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Packed-BCD addition over four nibbles, with a decimal adjust on each digit.
   function automatic logic [15:0] decimal_add(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] acc;
      logic        carry;
      logic [4:0]  s;
      acc   = '0;
      carry = 1'b0;
      for (int d = 0; d < 4; d++) begin
         s = {1'b0, a[4*d +: 4]} + {1'b0, b[4*d +: 4]} + {4'b0000, carry};
         if (s > 5'd9) begin
            s     = s - 5'd10;
            carry = 1'b1;
         end else begin
            carry = 1'b0;
         end
         acc[4*d +: 4] = s[3:0];
      end
      return acc;
   endfunction

   // Moves the scheduled hour on by an offset, falling back to the first hour
   // when the sum lands too late, or too early without an early press.
   task automatic reschedule(input logic [5:0] hr, input logic [5:0] offset);
      logic [15:0] next;
      next = decimal_add({10'd0, hr}, decimal_add(16'd0, {10'd0, offset}));
      if (next > {10'd0, last_hour} || (next < {10'd0, first_hour} && !early_mark)) begin
         sched_hour = first_hour;
         early_mark = 1'b0;
      end else begin
         sched_hour = next[5:0];
      end
   endtask

   task automatic silence_buzzer();
      pin       = 1'b0;
      sounding  = 1'b0;
      countdown = '0;
   endtask

   // Applies one event to the shadow state and returns the status it leads to.
   task automatic advance_alarm(input rabc_pkg::cmd_type c, input logic [5:0] hr,
                                output alarm_status_type st);
      case (c)
         rabc_pkg::CMD_TICK: begin
            if (sounding && countdown != 0) begin
               countdown = countdown - 10'd1;
               if (phase_ctr == rabc_pkg::BEEP_EVERY) begin
                  pin       = 1'b1;
                  phase_ctr = '0;
               end else begin
                  phase_ctr = phase_ctr + 3'd1;
                  pin       = 1'b0;
               end
            end else if (sounding) begin
               silence_buzzer();
               reschedule(hr, snooze_step);
            end else if (hr == sched_hour) begin
               pin       = 1'b1;
               sounding  = 1'b1;
               countdown = buzz_limit;
            end
         end
         rabc_pkg::CMD_PRESS: begin
            if (sounding || (!early_mark && hr < first_hour)) begin
               if (!sounding) early_mark = 1'b1;
               silence_buzzer();
               reschedule(hr, step_hours);
            end
         end
         rabc_pkg::CMD_START: begin
            sched_hour = first_hour;
            if (hr >= sched_hour) reschedule(hr, step_hours);
            silence_buzzer();
         end
         default: begin
         end
      endcase
      st.pin    = pin;
      st.active = sounding;
      st.hour   = sched_hour;
      st.secs   = sounding ? countdown : 10'd0;
   endtask

   // Sends one item after a random gap and records the status it should give.
   task automatic send_event(input rabc_pkg::cmd_type c, input logic [5:0] hr);
      int               gap;
      alarm_status_type st;
      gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, hr};
      req_tuser  <= c;
      do @(posedge clock); while (!req_tready);
      advance_alarm(c, hr, st);
      pending_status.push_back(st);
      items_sent++;
   endtask

   // Stops sending and waits until every expected result item has arrived.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   // Register write with a setup and an access cycle; the shadow copy follows it.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         rabc_pkg::REG_START_HOUR:     first_hour  = val[5:0];
         rabc_pkg::REG_ALARM_INTERVAL: step_hours  = val[5:0];
         rabc_pkg::REG_LATEST_HOUR:    last_hour   = val[5:0];
         rabc_pkg::REG_SNOOZE_HOURS:   snooze_step = val[5:0];
         rabc_pkg::REG_BUZZ_LIMIT:     buzz_limit  = val[9:0];
         default: begin
         end
      endcase
      csr_writes++;
   endtask

   task automatic set_config(input logic [5:0] s, input logic [5:0] i, input logic [5:0] l,
                             input logic [5:0] sn, input logic [9:0] lim);
      wait_idle();
      // Upper data bits carry noise; the block keeps only the register width.
      csr_write(rabc_pkg::REG_START_HOUR,     {8'($urandom_range(0, 255)), 18'd0, s});
      csr_write(rabc_pkg::REG_ALARM_INTERVAL, {26'(($urandom >> 6)), i});
      csr_write(rabc_pkg::REG_LATEST_HOUR,    {26'(($urandom >> 6)), l});
      csr_write(rabc_pkg::REG_SNOOZE_HOURS,   {26'(($urandom >> 6)), sn});
      csr_write(rabc_pkg::REG_BUZZ_LIMIT,     {22'(($urandom >> 10)), lim});
      settings++;
   endtask

   function automatic logic [5:0] rand_bcd_hour();
      logic [1:0] tens;
      logic [3:0] units;
      tens  = 2'($urandom_range(0, 2));
      units = 4'($urandom_range(0, 9));
      return {tens, units};
   endfunction

   function automatic logic [5:0] rand_cfg_hour();
      if ($urandom_range(0, 3) != 0) return rand_bcd_hour();
      return 6'($urandom_range(0, 63));
   endfunction

   // Mostly ticks at the scheduled hour and presses around the first hour, so
   // that buzzes start, run out and get silenced; the rest is noise.
   task automatic random_event();
      int                r;
      int                h;
      rabc_pkg::cmd_type c;
      logic [5:0]        hr;
      r = $urandom_range(0, 99);
      h = $urandom_range(0, 99);
      if (r < 65)      c = rabc_pkg::CMD_TICK;
      else if (r < 82) c = rabc_pkg::CMD_PRESS;
      else if (r < 90) c = rabc_pkg::CMD_START;
      else             c = rabc_pkg::CMD_NOP;
      if (h < 45)      hr = sched_hour;
      else if (h < 60) hr = 6'($urandom_range(0, first_hour));
      else if (h < 90) hr = rand_bcd_hour();
      else             hr = 6'($urandom_range(0, 63));
      send_event(c, hr);
   endtask

   // A run of random items, with one pause for the results to drain midway.
   task automatic run_random(input int n);
      for (int k = 0; k < n; k++) begin
         if (k == n / 2) wait_idle();
         random_event();
      end
   endtask

   // Directed events at the reset configuration: early press, start before and
   // after the first hour, a buzz that is silenced and one stopped by a start.
   task automatic test_default_events();
      send_event(rabc_pkg::CMD_NOP,   6'h3F);
      send_event(rabc_pkg::CMD_TICK,  6'h00);
      send_event(rabc_pkg::CMD_PRESS, 6'h05);
      send_event(rabc_pkg::CMD_PRESS, 6'h05);
      send_event(rabc_pkg::CMD_START, 6'h00);
      send_event(rabc_pkg::CMD_START, 6'h20);
      send_event(rabc_pkg::CMD_TICK,  6'h11);
      send_event(rabc_pkg::CMD_TICK,  6'h11);
      send_event(rabc_pkg::CMD_PRESS, 6'h11);
      send_event(rabc_pkg::CMD_TICK,  6'h15);
      send_event(rabc_pkg::CMD_NOP,   6'h15);
      send_event(rabc_pkg::CMD_START, 6'h15);
   endtask

   // A zero limit with non-BCD offsets: the buzz runs with a count of zero,
   // is snoozed by the next tick, and a press at zero count still silences it.
   task automatic test_zero_limit();
      set_config(6'h11, 6'h0F, 6'h19, 6'h3F, 10'd0);
      send_event(rabc_pkg::CMD_TICK,  6'h19);
      send_event(rabc_pkg::CMD_TICK,  6'h19);
      send_event(rabc_pkg::CMD_TICK,  6'h11);
      send_event(rabc_pkg::CMD_PRESS, 6'h11);
      send_event(rabc_pkg::CMD_TICK,  6'h3F);
      send_event(rabc_pkg::CMD_START, 6'h3F);
      send_event(rabc_pkg::CMD_PRESS, 6'h00);
   endtask

   // All registers at their highest values, and all but the buzz limit (set to one) at their lowest,
   // then writes to the unused addresses, which must leave the configuration alone.
   task automatic test_config_extremes();
      set_config(6'h00, 6'h00, 6'h00, 6'h00, 10'd1);
      run_random(60);
      set_config(6'h3F, 6'h3F, 6'h3F, 6'h3F, 10'h3FF);
      run_random(60);
      set_config(rabc_pkg::START_HOUR_RST, rabc_pkg::ALARM_INTERVAL_RST,
                 rabc_pkg::LATEST_HOUR_RST, rabc_pkg::SNOOZE_HOURS_RST, 10'd5);
      for (int k = rabc_pkg::REG_BUZZ_LIMIT + 1; k < 8; k++) csr_write(3'(k), $urandom);
      run_random(60);
   endtask

   // Random register settings, mostly with short buzz limits so that buzzes
   // expire often, and random idling on either side switched per phase.
   task automatic test_random_settings();
      int         r;
      logic [9:0] lim;
      for (int p = 0; p < 22; p++) begin
         r = $urandom_range(0, 99);
         if (r < 70)      lim = 10'($urandom_range(0, 12));
         else if (r < 90) lim = 10'($urandom_range(13, 60));
         else             lim = 10'($urandom_range(61, 1023));
         set_config(rand_cfg_hour(), rand_cfg_hour(), rand_cfg_hour(), rand_cfg_hour(), lim);
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         run_random(65);
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // Receiver: stalls for a random number of cycles before each result item.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compares each accepted result item with the oldest expected status.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = rsp_tdata[17:0];
         results_seen++;
         if (pending_status.size() == 0) begin
            $error("unexpected result item: tdata %06h", rsp_tdata);
            err_count++;
         end else begin
            want_status = pending_status.pop_front();
            if (got_status.pin !== want_status.pin) begin
               $error("buzz_pin: expected %0d, actual %0d", want_status.pin, got_status.pin);
               err_count++;
            end
            if (got_status.active !== want_status.active) begin
               $error("alarm_active: expected %0d, actual %0d",
                      want_status.active, got_status.active);
               err_count++;
            end
            if (got_status.hour !== want_status.hour) begin
               $error("next_alarm_hour: expected %02h, actual %02h",
                      want_status.hour, got_status.hour);
               err_count++;
            end
            if (got_status.secs !== want_status.secs) begin
               $error("seconds_left: expected %0d, actual %0d",
                      want_status.secs, got_status.secs);
               err_count++;
            end
         end
         stall_left = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
      end
   end

   // Watchdog on cycles in which nothing moves on any port.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL reminder_alarm_buzzer_controller_core");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = rabc_pkg::CMD_NOP;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_events();
      test_zero_limit();
      test_config_extremes();
      test_random_settings();

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_status.size() != 0) begin
         $error("%0d expected result items never arrived", pending_status.size());
         err_count++;
      end

      $display("Summary: %0d items sent, %0d results checked, %0d register writes, %0d settings.",
               items_sent, results_seen, csr_writes, settings);
      $display("Covered ticks, presses, starts and idle commands, zero and full-scale limits, "
               , "non-BCD hours and offsets.");
      if (err_count == 0) begin
         $display("PASS reminder_alarm_buzzer_controller_core");
      end else begin
         $display("FAIL reminder_alarm_buzzer_controller_core");
      end
      $finish;
   end

endmodule
